[rtl/ordered_list_table_engine_top_assert.svh]
// Assertion macros used by the ordered list table engine top level.
`ifndef ORDERED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/olte_pkg.sv]
// Package with the types and constants of the ordered list table engine.
`timescale 1ns / 1ps

package olte_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_SUM    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD0,
    S_DEL_TAKE,
    S_DEL_RD,
    S_DEL_WR,
    S_SRC_RD,
    S_SRC_CMP,
    S_SRC_SWP,
    S_SRC_SWP0,
    S_SUM_RD,
    S_SUM_ADD,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e                     mode;
    logic [4:0]                position;
    logic signed [DATA_W-1:0]  item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    status_e                   status;
    logic [4:0]                fill_count;
  } rsp_t;

endpackage

[rtl/olte_ram.sv]
// Single write port, single read port list storage with registered read data.
`timescale 1ns / 1ps

module olte_ram #(
  parameter int unsigned Depth = olte_pkg::CAPACITY_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [olte_pkg::DATA_W-1:0] wdata_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [olte_pkg::DATA_W-1:0] rdata_o
);

  logic [olte_pkg::DATA_W-1:0] mem [Depth];
  logic [olte_pkg::DATA_W-1:0] rdata_q;

  // Entries carry no reset; the sequencer only reads positions it has written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ordered_list_table_engine_top.sv]
// Top level of the ordered list table engine: command sequencer and result register.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------
//   in      | in_valid_i / in_ready_o | in_item_i   (olte_pkg::cmd_t)
//   out     | out_valid_o/out_ready_i | out_item_o  (olte_pkg::rsp_t)
//
// A command is paced by the single memory read port, the adder and the
// comparator, which the sequencer steps over the list one entry at a time.
// A new command is accepted only in the idle state, once the last one has finished.
// Reset (rst_ni, asynchronous, active low) empties the list; the entries themselves
// are not cleared, as no command reads beyond the current length.
// A finished result waits in the output register; the next transaction is taken while
// it waits, but a second result stalls in the final state until the first is taken.
`timescale 1ns / 1ps

module ordered_list_table_engine_top #(
  parameter int unsigned CAPACITY = olte_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  olte_pkg::cmd_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output olte_pkg::rsp_t out_item_o
);

  `include "ordered_list_table_engine_top_assert.svh"

  // Length counts 0 to CAPACITY; addresses only reach CAPACITY - 1.
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Comparison width: wide enough for the 5-bit position and for index + 2.
  localparam int unsigned CmpW  = (LenW + 1 > 5) ? LenW + 1 : 5;
  localparam int unsigned DW    = olte_pkg::DATA_W;

  olte_pkg::state_e  state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              out_valid_q, out_valid_d;

  // Working registers of the current command; they need no reset.
  logic [LenW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [DW-1:0]     key_q, key_d;
  logic [DW-1:0]     head_q, head_d;
  logic [DW-1:0]     acc_q, acc_d;
  olte_pkg::status_e stat_q, stat_d;
  olte_pkg::rsp_t    out_q, out_d;

  // Memory port signals.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [DW-1:0]     ram_rdata;

  // Index arithmetic and the compare unit.
  logic [LenW-1:0]   idx_m1, idx_p1;
  logic [CmpW-1:0]   pos_w, len_w, idx_w;
  logic [4:0]        fill_ext;
  logic              key_hit;
  logic              accept;

  assign idx_m1  = idx_q - LenW'(1);
  assign idx_p1  = idx_q + LenW'(1);
  assign pos_w   = CmpW'(in_item_i.position);
  assign len_w   = CmpW'(len_q);
  assign idx_w   = CmpW'(idx_q);
  assign key_hit = (ram_rdata == key_q);
  assign accept  = in_valid_i && in_ready_o;

  // The reported fill count is the length taken modulo 32.
  assign fill_ext = 5'(len_q);

  assign in_ready_o = (state_q == olte_pkg::S_IDLE);

  olte_ram #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olte_pkg::S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    head_q <= head_d;
    acc_q  <= acc_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    key_d       = key_q;
    head_d      = head_q;
    acc_d       = acc_q;
    stat_d      = stat_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AddrW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[AddrW-1:0];

    // The output register empties as soon as its transaction is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      olte_pkg::S_IDLE: begin
        if (accept) begin
          key_d = in_item_i.item_value;
          acc_d = '0;
          stat_d = olte_pkg::STAT_OK;
          idx_d = '0;
          unique case (in_item_i.mode)
            olte_pkg::MODE_INSERT: begin
              if (pos_w > len_w) begin
                stat_d  = olte_pkg::STAT_BAD;
                state_d = olte_pkg::S_DONE;
              end else if (len_w == CmpW'(CAPACITY)) begin
                stat_d  = olte_pkg::STAT_FULL;
                state_d = olte_pkg::S_DONE;
              end else begin
                pos_d   = pos_w[LenW-1:0];
                idx_d   = len_q;
                state_d = (len_w > pos_w) ? olte_pkg::S_INS_RD : olte_pkg::S_INS_PUT;
              end
            end
            olte_pkg::MODE_DELETE: begin
              if (pos_w >= len_w) begin
                stat_d  = olte_pkg::STAT_BAD;
                state_d = olte_pkg::S_DONE;
              end else begin
                idx_d   = pos_w[LenW-1:0];
                state_d = olte_pkg::S_DEL_RD0;
              end
            end
            olte_pkg::MODE_SEARCH: begin
              if (len_q == '0) begin
                stat_d  = olte_pkg::STAT_BAD;
                state_d = olte_pkg::S_DONE;
              end else begin
                state_d = olte_pkg::S_SRC_RD;
              end
            end
            olte_pkg::MODE_SUM: begin
              state_d = (len_q == '0) ? olte_pkg::S_DONE : olte_pkg::S_SUM_RD;
            end
            default: begin
              state_d = olte_pkg::S_DONE;
            end
          endcase
        end
      end

      // Insert: move entries up one place, from the tail down to the position.
      olte_pkg::S_INS_RD: begin
        ram_raddr = idx_m1[AddrW-1:0];
        state_d   = olte_pkg::S_INS_WR;
      end
      olte_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_m1;
        state_d   = (idx_m1 > pos_q) ? olte_pkg::S_INS_RD : olte_pkg::S_INS_PUT;
      end
      olte_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AddrW-1:0];
        ram_wdata = key_q;
        len_d     = len_q + LenW'(1);
        state_d   = olte_pkg::S_DONE;
      end

      // Delete: capture the entry, then move the later entries down one place.
      olte_pkg::S_DEL_RD0: begin
        state_d = olte_pkg::S_DEL_TAKE;
      end
      olte_pkg::S_DEL_TAKE: begin
        acc_d = ram_rdata;
        if (idx_w + CmpW'(1) < len_w) begin
          state_d = olte_pkg::S_DEL_RD;
        end else begin
          len_d   = len_q - LenW'(1);
          state_d = olte_pkg::S_DONE;
        end
      end
      olte_pkg::S_DEL_RD: begin
        ram_raddr = idx_p1[AddrW-1:0];
        state_d   = olte_pkg::S_DEL_WR;
      end
      olte_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_p1;
        if (idx_w + CmpW'(2) < len_w) begin
          state_d = olte_pkg::S_DEL_RD;
        end else begin
          len_d   = len_q - LenW'(1);
          state_d = olte_pkg::S_DONE;
        end
      end

      // Search: scan from the head; the head entry is kept for the swap.
      olte_pkg::S_SRC_RD: begin
        state_d = olte_pkg::S_SRC_CMP;
      end
      olte_pkg::S_SRC_CMP: begin
        if (idx_q == '0) begin
          head_d = ram_rdata;
        end
        if (key_hit) begin
          acc_d   = DW'(idx_q);
          state_d = (idx_q == '0) ? olte_pkg::S_DONE : olte_pkg::S_SRC_SWP;
        end else if (idx_w + CmpW'(1) < len_w) begin
          idx_d   = idx_p1;
          state_d = olte_pkg::S_SRC_RD;
        end else begin
          stat_d  = olte_pkg::STAT_BAD;
          state_d = olte_pkg::S_DONE;
        end
      end
      olte_pkg::S_SRC_SWP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        ram_wdata = head_q;
        state_d   = olte_pkg::S_SRC_SWP0;
      end
      olte_pkg::S_SRC_SWP0: begin
        // The found entry equals the key, so the key goes to the head.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        state_d   = olte_pkg::S_DONE;
      end

      // Sum: each entry is read, then added to the accumulator.
      olte_pkg::S_SUM_RD: begin
        state_d = olte_pkg::S_SUM_ADD;
      end
      olte_pkg::S_SUM_ADD: begin
        acc_d = acc_q + ram_rdata;
        if (idx_w + CmpW'(1) < len_w) begin
          idx_d   = idx_p1;
          state_d = olte_pkg::S_SUM_RD;
        end else begin
          state_d = olte_pkg::S_DONE;
        end
      end

      olte_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_value = acc_q;
          out_d.status       = stat_q;
          out_d.fill_count   = fill_ext;
          out_valid_d        = 1'b1;
          state_d            = olte_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olte_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `OLTE_ASSERT_NOW(a_len_in_range, 1'b1, len_q <= LenW'(CAPACITY), "list length exceeds capacity")
  `OLTE_ASSERT_NOW(a_len_moves_at_done, !$stable(len_q), state_q == olte_pkg::S_DONE, "length changed outside completion")
  `OLTE_ASSERT_NOW(a_out_from_done, $rose(out_valid_o), $past(state_q) == olte_pkg::S_DONE, "result appeared without completion")
  `OLTE_ASSERT_NEXT(a_accept_starts, accept, state_q != olte_pkg::S_IDLE, "accepted command did not start")

endmodule

[test/tb_ordered_list_table_engine_top.sv]
// Self-checking testbench for the ordered list table engine top level.
`timescale 1ns / 1ps

module tb_ordered_list_table_engine_top;

  // The list size matches the default build of the block under test.
  localparam int unsigned LIST_CAPACITY  = olte_pkg::CAPACITY_DEF;
  localparam int unsigned VALUE_W        = olte_pkg::DATA_W;
  // Length of the long receiver hold-off used to back the block up.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // This tail is longer than the slowest command, so it comfortably covers
  // anything still in flight once the queue is empty.
  localparam int unsigned TAIL_CYCLES    = 4 * LIST_CAPACITY + 20;
  // Worst case per transaction: longest command, longest sender gap and
  // longest receiver stall, summed over roughly 2000 transactions, plus the
  // hold-off; this limit is several times that.
  localparam int unsigned CYCLE_LIMIT    = 1_200_000;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  olte_pkg::cmd_t in_item_i;
  logic           out_valid_o;
  logic           out_ready_i;
  olte_pkg::rsp_t out_item_o;

  ordered_list_table_engine_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the list, updated the moment each command transaction is
  // accepted, so that stimulus choices can follow the real contents.
  logic signed [VALUE_W-1:0] shadow_list [LIST_CAPACITY];
  int unsigned               shadow_len;

  // Responses still owed by the block, oldest first.
  olte_pkg::rsp_t pending_rsp_q [$];
  olte_pkg::rsp_t want_rsp;
  int unsigned    error_count;
  int unsigned    cycle_count;

  // Idling controls; the receiver alone writes the served count, the main
  // sequence writes the rest.
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_off_requests;
  int unsigned hold_off_served;

  // Applies one command to the shadow list and returns the response that
  // the block must give for it.
  function automatic olte_pkg::rsp_t apply_command(input olte_pkg::cmd_t c);
    olte_pkg::rsp_t            r;
    logic signed [VALUE_W-1:0] swap_tmp;
    logic [VALUE_W-1:0]        total;
    int unsigned               p;
    int unsigned               i;
    bit                        found;

    r.result_value = '0;
    r.status       = olte_pkg::STAT_OK;
    p              = c.position;
    total          = '0;
    found          = 1'b0;
    case (c.mode)
      olte_pkg::MODE_INSERT: begin
        // A position past the end is refused before the full test is made.
        if (p > shadow_len) begin
          r.status = olte_pkg::STAT_BAD;
        end else if (shadow_len >= LIST_CAPACITY) begin
          r.status = olte_pkg::STAT_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) begin
            shadow_list[i] = shadow_list[i - 1];
          end
          shadow_list[p] = c.item_value;
          shadow_len++;
        end
      end
      olte_pkg::MODE_DELETE: begin
        if (p >= shadow_len) begin
          r.status = olte_pkg::STAT_BAD;
        end else begin
          r.result_value = shadow_list[p];
          for (i = p; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i + 1];
          end
          shadow_len--;
        end
      end
      olte_pkg::MODE_SEARCH: begin
        // The first match is swapped with the head entry.
        for (i = 0; i < shadow_len && !found; i++) begin
          if (shadow_list[i] == c.item_value) begin
            found          = 1'b1;
            swap_tmp       = shadow_list[i];
            shadow_list[i] = shadow_list[0];
            shadow_list[0] = swap_tmp;
            r.result_value = i;
          end
        end
        if (!found) begin
          r.status = olte_pkg::STAT_BAD;
        end
      end
      default: begin
        for (i = 0; i < shadow_len; i++) begin
          total = total + shadow_list[i];
        end
        r.result_value = total;
      end
    endcase
    r.fill_count = shadow_len[4:0];
    return r;
  endfunction

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;

    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Values lean on the extremes and on a small pool, so that searches hit
  // duplicates and sums wrap.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return $signed($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic olte_pkg::cmd_t command(input olte_pkg::mode_e m, input int unsigned pos,
                                             input logic signed [VALUE_W-1:0] v);
    olte_pkg::cmd_t c;

    c.mode       = m;
    c.position   = pos[4:0];
    c.item_value = v;
    return c;
  endfunction

  // Random command with the given mix of operations. Positions are mostly
  // legal for the current length; one in ten ranges over the whole field.
  function automatic olte_pkg::cmd_t random_command(input int unsigned w_ins,
                                                    input int unsigned w_del,
                                                    input int unsigned w_src,
                                                    input int unsigned w_sum);
    olte_pkg::cmd_t c;
    int unsigned    r;

    r = $urandom_range(0, w_ins + w_del + w_src + w_sum - 1);
    if (r < w_ins) begin
      c.mode = olte_pkg::MODE_INSERT;
    end else if (r < w_ins + w_del) begin
      c.mode = olte_pkg::MODE_DELETE;
    end else if (r < w_ins + w_del + w_src) begin
      c.mode = olte_pkg::MODE_SEARCH;
    end else begin
      c.mode = olte_pkg::MODE_SUM;
    end
    if ($urandom_range(0, 9) == 0) begin
      c.position = 5'($urandom_range(0, 31));
    end else if (c.mode == olte_pkg::MODE_DELETE && shadow_len > 0) begin
      c.position = 5'($urandom_range(0, shadow_len - 1));
    end else begin
      c.position = 5'($urandom_range(0, shadow_len));
    end
    c.item_value = pick_value();
    if (c.mode == olte_pkg::MODE_SEARCH && shadow_len > 0 && $urandom_range(0, 3) != 0) begin
      c.item_value = shadow_list[$urandom_range(0, shadow_len - 1)];
    end
    return c;
  endfunction

  // Offers one command transaction and waits for it to be accepted. The
  // valid line stays high afterwards, so a back-to-back command follows with
  // no gap; a gap is opened at the next falling edge instead.
  task automatic send_command(input olte_pkg::cmd_t c);
    int unsigned gap;

    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) >= 55) begin
      gap = idle_length();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= c;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_rsp_q.push_back(apply_command(c));
  endtask

  // Stops offering commands and waits until every owed response has come.
  task automatic drain_responses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
    error_count++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the main sequence
  // asks for one. The hold-off is counted here, in cycles, while the sender
  // keeps offering commands.
  initial begin : receiver
    int unsigned stall;

    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_requests != hold_off_served) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_served++;
      end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
        stall = idle_length();
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Response checker: each response transaction is matched against the
  // oldest owed response, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", out_item_o.result_value, '0);
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (out_item_o.result_value !== want_rsp.result_value) begin
          report_mismatch("result_value", out_item_o.result_value, want_rsp.result_value);
        end
        if (out_item_o.status !== want_rsp.status) begin
          report_mismatch("status", VALUE_W'(out_item_o.status), VALUE_W'(want_rsp.status));
        end
        if (out_item_o.fill_count !== want_rsp.fill_count) begin
          report_mismatch("fill_count", VALUE_W'(out_item_o.fill_count),
                          VALUE_W'(want_rsp.fill_count));
        end
      end
    end
  end

  // Watchdog: ends a run that has hung.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d responses owed", cycle_count,
             pending_rsp_q.size());
    $display("FAIL");
    $finish;
  end

  // Hand-picked commands: the empty list, each operation, the value
  // extremes, positions past the end, a head hit, a swapping hit, a miss,
  // wrapping sums and deletes at the head, middle and tail.
  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_command(command(olte_pkg::MODE_SUM,    0,  0));
    send_command(command(olte_pkg::MODE_DELETE, 0,  0));
    send_command(command(olte_pkg::MODE_SEARCH, 0,  0));
    send_command(command(olte_pkg::MODE_INSERT, 1,  7));
    send_command(command(olte_pkg::MODE_INSERT, 0,  32'h7fff_ffff));
    send_command(command(olte_pkg::MODE_INSERT, 1,  32'h8000_0000));
    send_command(command(olte_pkg::MODE_INSERT, 2,  32'h7fff_ffff));
    send_command(command(olte_pkg::MODE_INSERT, 0,  -1));
    send_command(command(olte_pkg::MODE_SUM,    0,  0));
    send_command(command(olte_pkg::MODE_INSERT, 1,  5));
    send_command(command(olte_pkg::MODE_SEARCH, 0,  -1));
    send_command(command(olte_pkg::MODE_SEARCH, 0,  32'h8000_0000));
    send_command(command(olte_pkg::MODE_SEARCH, 0,  1234));
    send_command(command(olte_pkg::MODE_SEARCH, 31, 32'h7fff_ffff));
    send_command(command(olte_pkg::MODE_DELETE, 31, 0));
    send_command(command(olte_pkg::MODE_DELETE, 5,  0));
    send_command(command(olte_pkg::MODE_INSERT, 6,  9));
    send_command(command(olte_pkg::MODE_INSERT, 31, 0));
    send_command(command(olte_pkg::MODE_DELETE, 2,  0));
    send_command(command(olte_pkg::MODE_DELETE, 0,  0));
    send_command(command(olte_pkg::MODE_DELETE, 2,  0));
    send_command(command(olte_pkg::MODE_SUM,    0,  0));
    drain_responses();
  endtask

  // Fills the list to capacity, then tries inserts that must be refused as
  // full, an insert past the end of a full list, and a delete and refill.
  task automatic test_full_list();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (shadow_len < LIST_CAPACITY) begin
      send_command(command(olte_pkg::MODE_INSERT, $urandom_range(0, shadow_len),
                           pick_value()));
    end
    send_command(command(olte_pkg::MODE_INSERT, 0, 1));
    send_command(command(olte_pkg::MODE_INSERT, LIST_CAPACITY, 1));
    send_command(command(olte_pkg::MODE_INSERT, LIST_CAPACITY + 1, 1));
    send_command(command(olte_pkg::MODE_SUM, 0, 0));
    send_command(command(olte_pkg::MODE_SEARCH, 0, shadow_list[LIST_CAPACITY - 1]));
    send_command(command(olte_pkg::MODE_DELETE, LIST_CAPACITY, 0));
    send_command(command(olte_pkg::MODE_DELETE, LIST_CAPACITY - 1, 0));
    send_command(command(olte_pkg::MODE_INSERT, LIST_CAPACITY - 1, 32'h8000_0000));
    send_command(command(olte_pkg::MODE_SEARCH, 0, 32'h8000_0000));
    drain_responses();
  endtask

  // The receiver holds off for a long stretch while commands are offered
  // back to back, so the block fills up and has to stall its input.
  task automatic test_hold_off();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_off_requests++;
    repeat (16) begin
      send_command(random_command(30, 20, 30, 20));
    end
    drain_responses();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned w_ins,
                                     input int unsigned w_del, input int unsigned w_src,
                                     input int unsigned w_sum, input bit idle_en);
    tx_idle_en = idle_en;
    rx_idle_en = idle_en;
    repeat (count) begin
      send_command(random_command(w_ins, w_del, w_src, w_sum));
    end
    drain_responses();
  endtask

  // Main sequence: reset once, then each test in turn.
  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_item_i         = '0;
    tx_idle_en        = 1'b0;
    rx_idle_en        = 1'b0;
    hold_off_requests = 0;
    hold_off_served   = 0;
    shadow_len        = 0;
    error_count       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_list();
    test_hold_off();
    // Balanced traffic, then mixes that push the list towards full and
    // towards empty, a stretch with no idling and a search-heavy mix.
    test_random_traffic(500, 30, 20, 30, 20, 1'b1);
    test_random_traffic(300, 60, 10, 20, 10, 1'b1);
    test_random_traffic(300, 15, 55, 20, 10, 1'b1);
    test_random_traffic(300, 30, 20, 30, 20, 1'b0);
    test_random_traffic(450, 30, 15, 45, 10, 1'b1);

    // Give any stray response time to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
